// File: design/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 9;
    localparam int COUNT_W  = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIND   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK     = 3'd0,
        STAT_FULL   = 3'd1,
        STAT_DUP    = 3'd2,
        STAT_EMPTY  = 3'd3,
        STAT_ABSENT = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DEL_ROOT,
        ST_DEL_LAST,
        ST_DEL_GRAB,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_SEL,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        status_t                   status;
        logic signed [KEY_W-1:0]   removed_max;
        logic        [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

// File: design/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/mhpq_ctrl.sv
// Sequencer and datapath: scan, sift-up and sift-down over the heap RAM.
module mhpq_ctrl
    import mhpq_pkg::*;
#(
    parameter int MAX_ENTRIES = 256,
    parameter int ADDR_W      = $clog2(MAX_ENTRIES),
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [KEY_W-1:0] key,
    output logic                    out_valid,
    input  logic                    out_ready,
    output result_t                 res,
    input  logic [CNT_W-1:0]        limit,
    input  logic                    cfg_clear,
    output logic                    ram_we,
    output logic [ADDR_W-1:0]       ram_waddr,
    output logic [KEY_W-1:0]        ram_wdata,
    output logic [ADDR_W-1:0]       ram_raddr,
    input  logic [KEY_W-1:0]        ram_rdata
);

    localparam int CW = ADDR_W + 2;

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    rem_reg, rem_next;
    logic [KEY_W-1:0]    last_reg, last_next;
    logic [KEY_W-1:0]    child_reg, child_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;
    logic [ADDR_W-1:0]   cidx_reg, cidx_next;
    logic                chk_reg, chk_next;
    status_t             stat_reg, stat_next;
    logic                out_valid_reg, out_valid_next;
    result_t             res_reg, res_next;

    logic                is_full, occ_zero;
    logic                scan_issue, scan_hit, scan_miss;
    logic                is_root;
    logic [ADDR_W-1:0]   parent_idx, left_idx, right_idx;
    logic [CW-1:0]       left_ext, occ_ext;
    logic                has_left, has_right;
    logic [CNT_W-1:0]    occ_dec;
    logic                fin_load;
    logic [KEY_W-1:0]    cmp_a, cmp_b;
    logic                lt;

    assign is_full    = occ_reg >= limit;
    assign occ_zero   = occ_reg == '0;
    assign scan_issue = idx_reg < occ_reg;
    assign scan_hit   = chk_reg && (ram_rdata == key_reg);
    assign scan_miss  = !scan_issue && !chk_reg;
    assign is_root    = pos_reg == '0;
    assign parent_idx = (pos_reg - 1'b1) >> 1;
    assign left_ext   = {1'b0, pos_reg, 1'b1};
    assign occ_ext    = CW'(occ_reg);
    assign has_left   = left_ext < occ_ext;
    assign has_right  = (left_ext + CW'(1)) < occ_ext;
    assign left_idx   = left_ext[ADDR_W-1:0];
    assign right_idx  = left_idx + 1'b1;
    assign occ_dec    = occ_reg - 1'b1;
    assign fin_load   = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    // shared signed less-than unit
    always_comb
    begin
        unique case (state_reg)
            ST_UP_CMP:
            begin
                cmp_a = ram_rdata;
                cmp_b = key_reg;
            end
            ST_DN_SEL:
            begin
                cmp_a = child_reg;
                cmp_b = ram_rdata;
            end
            default:
            begin
                cmp_a = last_reg;
                cmp_b = child_reg;
            end
        endcase
    end

    assign lt = $signed(cmp_a) < $signed(cmp_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority case (mode)
                        MODE_INSERT:
                        begin
                            if (is_full)
                                state_next = ST_FINISH;
                            else if (occ_zero)
                                state_next = ST_UP_RD;
                            else
                                state_next = ST_SCAN;
                        end
                        MODE_DELETE:
                            state_next = occ_zero ? ST_FINISH : ST_DEL_ROOT;
                        MODE_FIND:
                            state_next = occ_zero ? ST_FINISH : ST_SCAN;
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                    state_next = ST_FINISH;
                else if (scan_miss)
                    state_next = (mode_reg == MODE_INSERT) ? ST_UP_RD : ST_FINISH;
            end
            ST_UP_RD:
                state_next = is_root ? ST_FINISH : ST_UP_CMP;
            ST_UP_CMP:
                state_next = lt ? ST_UP_RD : ST_FINISH;
            ST_DEL_ROOT:
                state_next = ST_DEL_LAST;
            ST_DEL_LAST:
                state_next = ST_DEL_GRAB;
            ST_DEL_GRAB:
                state_next = ST_DN_LEFT;
            ST_DN_LEFT:
                state_next = has_left ? ST_DN_RIGHT : ST_FINISH;
            ST_DN_RIGHT:
                state_next = has_right ? ST_DN_SEL : ST_DN_CMP;
            ST_DN_SEL:
                state_next = ST_DN_CMP;
            ST_DN_CMP:
                state_next = lt ? ST_DN_LEFT : ST_FINISH;
            ST_FINISH:
            begin
                if (fin_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        mode_next      = mode_reg;
        key_next       = key_reg;
        rem_next       = rem_reg;
        last_next      = last_reg;
        child_next     = child_reg;
        occ_next       = occ_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        cidx_next      = cidx_reg;
        chk_next       = chk_reg;
        stat_next      = stat_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    key_next  = key;
                    rem_next  = '0;
                    idx_next  = '0;
                    chk_next  = 1'b0;
                    pos_next  = occ_reg[ADDR_W-1:0];
                    if (mode == MODE_INSERT && is_full)
                        stat_next = STAT_FULL;
                    else if (mode == MODE_DELETE && occ_zero)
                        stat_next = STAT_EMPTY;
                    else if (mode == MODE_FIND && occ_zero)
                        stat_next = STAT_ABSENT;
                    else
                        stat_next = STAT_OK;
                end
            end
            ST_SCAN:
            begin
                chk_next = scan_issue;
                if (scan_issue)
                    idx_next = idx_reg + 1'b1;
                if (scan_hit && mode_reg == MODE_INSERT)
                    stat_next = STAT_DUP;
                if (scan_miss)
                begin
                    pos_next = occ_reg[ADDR_W-1:0];
                    if (mode_reg == MODE_FIND)
                        stat_next = STAT_ABSENT;
                end
            end
            ST_UP_RD:
            begin
                if (is_root)
                    occ_next = occ_reg + 1'b1;
            end
            ST_UP_CMP:
            begin
                if (lt)
                    pos_next = parent_idx;
                else
                    occ_next = occ_reg + 1'b1;
            end
            ST_DEL_LAST:
                rem_next = ram_rdata;
            ST_DEL_GRAB:
            begin
                last_next = ram_rdata;
                occ_next  = occ_dec;
                pos_next  = '0;
            end
            ST_DN_RIGHT:
            begin
                child_next = ram_rdata;
                cidx_next  = left_idx;
            end
            ST_DN_SEL:
            begin
                if (lt)
                begin
                    child_next = ram_rdata;
                    cidx_next  = cidx_reg + 1'b1;
                end
            end
            ST_DN_CMP:
            begin
                if (lt)
                    pos_next = cidx_reg;
            end
            ST_FINISH:
            begin
                if (fin_load)
                begin
                    res_next.status      = stat_reg;
                    res_next.removed_max = rem_reg;
                    res_next.entry_count = COUNT_W'(occ_reg);
                    out_valid_next       = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // capacity write empties the heap
        if (cfg_clear)
            occ_next = '0;
    end

    // RAM control and handshake outputs
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = last_reg;
        ram_raddr = '0;
        unique case (state_reg)
            ST_SCAN:
                ram_raddr = idx_reg[ADDR_W-1:0];
            ST_UP_RD:
            begin
                if (is_root)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = key_reg;
                end
                else
                begin
                    ram_raddr = parent_idx;
                end
            end
            ST_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = lt ? ram_rdata : key_reg;
            end
            ST_DEL_LAST:
                ram_raddr = occ_dec[ADDR_W-1:0];
            ST_DN_LEFT:
            begin
                if (has_left)
                    ram_raddr = left_idx;
                else
                    ram_we = 1'b1;
            end
            ST_DN_RIGHT:
                ram_raddr = right_idx;
            ST_DN_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = lt ? child_reg : last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        key_reg   <= key_next;
        rem_reg   <= rem_next;
        last_reg  <= last_next;
        child_reg <= child_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        cidx_reg  <= cidx_next;
        chk_reg   <= chk_next;
        stat_reg  <= stat_next;
        res_reg   <= res_next;
    end

endmodule

// File: design/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: capacity register, heap RAM, sequencer.
//
//  channel   signals                               direction
//  request   in_valid/in_ready, mode, key          in
//  result    out_valid/out_ready, status,          out
//            removed_max, entry_count
//  config    cfg_we, cfg_data (capacity)           in
//
// Insert and find scan the held keys at one RAM read per cycle, as the RAM has a single read
// port. Insert then sifts up with a parent read and a compare-and-write per level; delete
// fetches the root and last key in its root, last and grab states, then sifts down per level
// through a left read, a right read, a child select and a compare-and-write. Reset empties the
// heap, no clearing pass. A finished result waits in the output register; the next request is
// taken meanwhile and stalls only at its own finish until the previous result is taken.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [MODE_W-1:0]          mode,
    input  logic signed [KEY_W-1:0]    key,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [STATUS_W-1:0]        status,
    output logic signed [KEY_W-1:0]    removed_max,
    output logic [COUNT_W-1:0]         entry_count,
    input  logic                       cfg_we,
    input  logic [CAP_W-1:0]           cfg_data
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LW     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]  cap_reg;
    logic [LW-1:0]     cap_ext, max_ext, lim_ext;
    logic [CNT_W-1:0]  limit;
    result_t           res;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [KEY_W-1:0]  ram_wdata, ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_data;
    end

    // clamp capacity to the store depth
    assign cap_ext = LW'(cap_reg);
    assign max_ext = LW'(MAX_ENTRIES);
    assign lim_ext = (cap_ext > max_ext) ? max_ext : cap_ext;
    assign limit   = lim_ext[CNT_W-1:0];

    mhpq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mhpq_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_W      (ADDR_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res       (res),
        .limit     (limit),
        .cfg_clear (cfg_we),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    assign status      = res.status;
    assign removed_max = res.removed_max;
    assign entry_count = res.entry_count;

endmodule

// File: dv/heap_result_monitor.sv
// Result monitor for the max-heap priority queue: predicts every request's result and checks it.
`timescale 1ns / 100ps
module heap_result_monitor
    import mhpq_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [KEY_W-1:0] key,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic [STATUS_W-1:0]     status,
    input  logic signed [KEY_W-1:0] removed_max,
    input  logic [COUNT_W-1:0]      entry_count,
    input  logic                    cfg_we,
    input  logic [CAP_W-1:0]        cfg_data,
    output int                      errors,
    output int                      pending,
    output int                      checked,
    output int                      peak_fill
);

    logic signed [KEY_W-1:0] heap_keys [DEPTH];
    int                      held;
    logic [CAP_W-1:0]        cap_reg;
    result_t                 awaited_results [$];

    function automatic bit key_stored(input logic signed [KEY_W-1:0] k);
        for (int i = 0; i < held; i++)
        begin
            if (heap_keys[i] == k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the heap image by one request and return the result it must produce.
    function automatic result_t apply_request(input logic [MODE_W-1:0] m,
                                              input logic signed [KEY_W-1:0] k);
        result_t                 r;
        int                      limit;
        int                      slot;
        int                      parent;
        int                      child;
        int                      n;
        logic signed [KEY_W-1:0] last;
        r.status      = STAT_OK;
        r.removed_max = '0;
        limit         = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
        case (m)
            MODE_INSERT:
            begin
                // full wins over duplicate
                if (held >= limit)
                    r.status = STAT_FULL;
                else if (key_stored(k))
                    r.status = STAT_DUP;
                else
                begin
                    slot = held;
                    while (slot > 0)
                    begin
                        parent = (slot - 1) / 2;
                        if (heap_keys[parent] >= k)
                            break;
                        heap_keys[slot] = heap_keys[parent];
                        slot = parent;
                    end
                    heap_keys[slot] = k;
                    held++;
                end
            end
            MODE_DELETE:
            begin
                if (held == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.removed_max = heap_keys[0];
                    n    = held - 1;
                    last = heap_keys[n];
                    held = n;
                    slot = 0;
                    while (2 * slot + 1 < n)
                    begin
                        child = 2 * slot + 1;
                        if (child + 1 < n && heap_keys[child] < heap_keys[child + 1])
                            child++;
                        if (last < heap_keys[child])
                        begin
                            heap_keys[slot] = heap_keys[child];
                            slot = child;
                        end
                        else
                            break;
                    end
                    heap_keys[slot] = last;
                end
            end
            MODE_FIND:
            begin
                if (!key_stored(k))
                    r.status = STAT_ABSENT;
            end
            default:
            begin
            end
        endcase
        r.entry_count = COUNT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            held    = 0;
            cap_reg = CAP_RESET;
            awaited_results.delete();
        end
        else
        begin
            // a capacity write empties the heap
            if (cfg_we)
            begin
                cap_reg = cfg_data;
                held    = 0;
            end
            if (out_valid && out_ready)
            begin
                checked++;
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result %0d arrived with no request waiting",
                                 $time, checked);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (status !== want.status || removed_max !== want.removed_max ||
                        entry_count !== want.entry_count)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: result %0d expected status %0d max %0d count %0d",
                                     $time, checked, want.status,
                                     $signed(want.removed_max), want.entry_count);
                            $display("    got status %0d max %0d count %0d",
                                     status, removed_max, entry_count);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                awaited_results.push_back(apply_request(mode, key));
        end
        pending = awaited_results.size();
        if (held > peak_fill)
            peak_fill = held;
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the max-heap priority queue: clock, reset, request and capacity stimulus.
`timescale 1ns / 100ps
module tb_top;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH       = 256;
    localparam int STALL_LIMIT      = 4000;
    localparam int TAIL_CYCLES      = 300;
    localparam int SMALL_PHASE_REQS = 90;
    localparam int FILL_REQS        = 330;
    localparam int DRAIN_REQS       = 110;
    localparam int NUM_PHASES       = 14;

    localparam logic [MODE_W-1:0]       MODE_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX     = 32'sh7fff_ffff;

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    in_valid    = 1'b0;
    logic                    in_ready;
    logic [MODE_W-1:0]       mode        = '0;
    logic signed [KEY_W-1:0] key         = '0;
    logic                    out_valid;
    logic                    out_ready   = 1'b0;
    logic [STATUS_W-1:0]     status;
    logic signed [KEY_W-1:0] removed_max;
    logic [COUNT_W-1:0]      entry_count;
    logic                    cfg_we      = 1'b0;
    logic [CAP_W-1:0]        cfg_data    = '0;

    int errors;
    int pending;
    int checked;
    int peak_fill;

    int stall_cycles = 0;
    int rx_hold      = 0;
    bit rx_quiet     = 1'b0;
    int mode_sent [4];
    int cap_writes   = 0;

    logic signed [KEY_W-1:0] recent_keys [16];
    int                      recent_wr = 0;

    int cap_plan [NUM_PHASES] = '{1, 511, 2, 3, 5, 8, 0, 16, 31, 256, 64, 4, 12, 100};

    always #1 clk = ~clk;

    max_heap_priority_queue #(
        .MAX_ENTRIES (HEAP_DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .removed_max (removed_max),
        .entry_count (entry_count),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    heap_result_monitor #(
        .DEPTH (HEAP_DEPTH)
    ) u_result_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .key         (key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .removed_max (removed_max),
        .entry_count (entry_count),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .peak_fill   (peak_fill)
    );

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [KEY_W-1:0] choose_key(input int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < pool_pct)
            return int'($urandom_range(0, 16)) - 8;
        if (r < pool_pct + 3)
        begin
            case ($urandom_range(0, 3))
                0:       return KEY_MIN;
                1:       return KEY_MAX;
                2:       return KEY_MIN + 1;
                default: return KEY_MAX - 1;
            endcase
        end
        if (r < pool_pct + 15)
            return recent_keys[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic logic [MODE_W-1:0] choose_mode(input int ins_pct, input int del_pct,
                                                      input int find_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            return MODE_INSERT;
        if (r < ins_pct + del_pct)
            return MODE_DELETE;
        if (r < ins_pct + del_pct + find_pct)
            return MODE_FIND;
        return MODE_UNUSED;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic present_request(input logic [MODE_W-1:0] m,
                                   input logic signed [KEY_W-1:0] k, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        key      <= k;
        mode_sent[m]++;
        if (m == MODE_INSERT)
        begin
            recent_keys[recent_wr] = k;
            recent_wr = (recent_wr + 1) % 16;
        end
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold requests back until every outstanding result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic write_capacity(input int value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value[CAP_W-1:0];
        cap_writes++;
        @(negedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic run_phase(input int cap);
        int                reqs;
        bit                big;
        bit                tx_quiet;
        logic [MODE_W-1:0] m;
        big  = (cap >= 200);
        reqs = big ? FILL_REQS + DRAIN_REQS : SMALL_PHASE_REQS;
        write_capacity(cap);
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet <= ($urandom_range(0, 3) == 0);
        for (int i = 0; i < reqs; i++)
        begin
            // large settings: fill to the limit with mostly fresh keys, then mostly drain
            if (!big)
                m = choose_mode(45, 30, 20);
            else if (i < FILL_REQS)
                m = choose_mode(94, 0, 5);
            else
                m = choose_mode(15, 70, 13);
            if ($urandom_range(0, 63) == 0)
                drain_results();
            present_request(m, choose_key(big ? 3 : 40), tx_quiet ? 0 : idle_length());
        end
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold   <= rx_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_quiet)
                rx_hold <= idle_length();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        foreach (recent_keys[i])
            recent_keys[i] = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty heap, unused mode, extremes, duplicates, ordering on delete
        present_request(MODE_DELETE, '0, idle_length());
        present_request(MODE_FIND, '0, idle_length());
        present_request(MODE_UNUSED, 32'sd123, idle_length());
        present_request(MODE_INSERT, KEY_MIN, idle_length());
        present_request(MODE_INSERT, KEY_MAX, idle_length());
        present_request(MODE_INSERT, '0, idle_length());
        present_request(MODE_INSERT, -32'sd1, idle_length());
        present_request(MODE_INSERT, 32'sd1, idle_length());
        present_request(MODE_INSERT, '0, idle_length());
        present_request(MODE_INSERT, KEY_MAX, idle_length());
        present_request(MODE_FIND, KEY_MIN, idle_length());
        present_request(MODE_FIND, 32'sh5555_5555, idle_length());
        present_request(MODE_INSERT, 32'shaaaa_aaaa, idle_length());
        present_request(MODE_DELETE, 32'sh7777_7777, idle_length());
        present_request(MODE_DELETE, '0, idle_length());
        present_request(MODE_UNUSED, -32'sd1, idle_length());

        // zero capacity refuses every insert
        write_capacity(0);
        present_request(MODE_INSERT, 32'sd7, idle_length());
        present_request(MODE_DELETE, '0, idle_length());

        // full is reported ahead of duplicate
        write_capacity(2);
        present_request(MODE_INSERT, 32'sd3, idle_length());
        present_request(MODE_INSERT, 32'sd9, idle_length());
        present_request(MODE_INSERT, 32'sd3, idle_length());
        present_request(MODE_INSERT, 32'sd4, idle_length());
        present_request(MODE_DELETE, '0, idle_length());
        present_request(MODE_DELETE, '0, idle_length());
        present_request(MODE_DELETE, '0, idle_length());

        for (int p = 0; p < NUM_PHASES; p++)
            run_phase(cap_plan[p]);

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Sent %0d requests: %0d insert, %0d delete-max, %0d find, %0d unused mode",
                 mode_sent[0] + mode_sent[1] + mode_sent[2] + mode_sent[3],
                 mode_sent[0], mode_sent[1], mode_sent[2], mode_sent[3]);
        $display("Checked %0d results over %0d capacity writes, peak occupancy %0d",
                 checked, cap_writes, peak_fill);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
